>>> sv/scod_pkg.sv
// Shared types, constants and a helper function of the sequencer clock output divider.
package scod_pkg;

    localparam int NUM_REGS            = 5;
    localparam int MAX_PORTS           = 8;
    localparam int MAX_RESULTS         = 8;
    localparam int DEFAULT_PORTS       = 5;
    localparam int DEFAULT_ANALOG_PORT = 2;
    localparam int DEFAULT_PULSE_LEN   = 10;
    localparam int CFG_INDEX_W         = 3;
    localparam int DATA_W              = 8;
    localparam int PORT_W              = 3;
    localparam int JOB_DEPTH           = 4;
    localparam int JOB_PTR_W           = $clog2(JOB_DEPTH);
    localparam int JOB_CNT_W           = $clog2(JOB_DEPTH + 1);

    typedef enum logic [1:0] {
        REQ_CLOCK = 2'd0,
        REQ_TIMER = 2'd1,
        REQ_RUN   = 2'd2
    } req_type_t;

    typedef enum logic [2:0] {
        MSG_NONE     = 3'd0,
        MSG_TICK     = 3'd1,
        MSG_START    = 3'd2,
        MSG_CONTINUE = 3'd3,
        MSG_STOP     = 3'd4
    } msg_kind_t;

    typedef enum logic {
        FRONT_READY,
        FRONT_DIVIDE
    } front_state_t;

    typedef struct packed {
        req_type_t req_type;
        logic      at_position_zero;
        logic      run_request;
    } req_t;

    typedef struct packed {
        msg_kind_t         msg_kind;
        logic [PORT_W-1:0] port;
        logic              analog_clock;
        logic              analog_reset;
        logic              last;
    } res_t;

    typedef struct packed {
        msg_kind_t            run_kind;
        logic [MAX_PORTS-1:0] run_mask;
        logic [MAX_PORTS-1:0] tick_mask;
        logic                 analog_clock;
        logic                 analog_reset;
    } job_t;

    function automatic logic [PORT_W-1:0] lowest_index(input logic [MAX_PORTS-1:0] mask);
        logic [PORT_W-1:0] idx;
        idx = '0;
        for (int i = MAX_PORTS - 1; i >= 0; i--) begin
            if (mask[i])
            begin
                idx = PORT_W'(i);
            end
        end
        return idx;
    endfunction

endpackage

>>> sv/scod_job_queue.sv
// Short queue of message jobs between the front and the back.
module scod_job_queue
    import scod_pkg::*;
(
    input  logic clk,
    input  logic rst_n,
    input  logic push,
    input  job_t job_in,
    output logic full,
    input  logic pop,
    output job_t job_out,
    output logic empty
);

    job_t                 mem_reg [JOB_DEPTH];
    logic [JOB_PTR_W-1:0] wr_ptr_reg;
    logic [JOB_PTR_W-1:0] rd_ptr_reg;
    logic [JOB_CNT_W-1:0] count_reg;
    logic                 do_push;
    logic                 do_pop;

    assign full    = (count_reg == JOB_CNT_W'(JOB_DEPTH));
    assign empty   = (count_reg == '0);
    assign do_push = push && !full;
    assign do_pop  = pop && !empty;
    assign job_out = mem_reg[rd_ptr_reg];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (do_push)
            begin
                wr_ptr_reg <= wr_ptr_reg + JOB_PTR_W'(1);
            end
            if (do_pop)
            begin
                rd_ptr_reg <= rd_ptr_reg + JOB_PTR_W'(1);
            end
            if (do_push && !do_pop)
            begin
                count_reg <= count_reg + JOB_CNT_W'(1);
            end
            else if (do_pop && !do_push)
            begin
                count_reg <= count_reg - JOB_CNT_W'(1);
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            mem_reg[wr_ptr_reg] <= job_in;
        end
    end

endmodule

>>> sv/scod_front.sv
// Front part: takes requests, keeps run state, dividers and analog pulses, and builds message jobs.
module scod_front
    import scod_pkg::*;
#(
    parameter int PORTS       = DEFAULT_PORTS,
    parameter int ANALOG_PORT = DEFAULT_ANALOG_PORT,
    parameter int PULSE_LEN   = DEFAULT_PULSE_LEN
)
(
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   cfg_write,
    input  logic [CFG_INDEX_W-1:0] cfg_index,
    input  logic [DATA_W-1:0]      cfg_data,
    input  logic                   accept,
    input  req_t                   request,
    output logic                   busy,
    output job_t                   job
);

    localparam logic [7:0] PULSE_LOAD = 8'(PULSE_LEN + 1);

    front_state_t state_reg;
    front_state_t state_next;

    logic [7:0] div_reg [NUM_REGS];
    logic [7:0] port_div [PORTS];
    logic [PORTS-1:0] en;
    logic [PORTS-1:0] msg_en;
    logic             analog_en;
    logic             analog_hit;

    logic       wanted_run_reg, wanted_run_next;
    logic       running_reg, running_next;
    logic [7:0] run_cnt_reg [PORTS];
    logic [7:0] run_cnt_next [PORTS];
    logic [7:0] stop_cnt_reg [PORTS];
    logic [7:0] stop_cnt_next [PORTS];
    logic [7:0] clock_left_reg, clock_left_next;
    logic       delayed_clock_reg, delayed_clock_next;
    logic [7:0] reset_left_reg, reset_left_next;
    logic       clock_level_reg, clock_level_next;
    logic       reset_level_reg, reset_level_next;

    logic [8:0] dividend_reg [PORTS];
    logic [7:0] rem_reg [PORTS];
    logic [7:0] rem_step [PORTS];
    logic [3:0] bit_reg;

    logic       at_zero;
    logic       change;
    logic       do_start;
    logic       do_stop;
    logic       pulse_start;
    logic [7:0] reset_left_tick;
    logic [7:0] run0 [PORTS];
    logic [7:0] stop1 [PORTS];
    logic [7:0] sel_cnt [PORTS];
    logic [8:0] inc_cnt [PORTS];
    logic [7:0] fast_cnt [PORTS];
    logic [PORTS-1:0] hit;
    logic [PORTS-1:0] over;
    logic       slow;
    logic       clock_req;
    logic       start_divide;
    logic       divide_done;

    genvar g;
    generate
        for (g = 0; g < PORTS; g++)
        begin : g_lane
            if (g < NUM_REGS)
            begin : g_reg
                assign port_div[g] = div_reg[g];
            end
            else
            begin : g_none
                assign port_div[g] = 8'd0;
            end
            assign en[g]     = (port_div[g] != 8'd0);
            assign msg_en[g] = en[g] && (g != ANALOG_PORT);
        end
        if (ANALOG_PORT < PORTS)
        begin : g_analog
            assign analog_en  = en[ANALOG_PORT];
            assign analog_hit = hit[ANALOG_PORT];
        end
        else
        begin : g_no_analog
            assign analog_en  = 1'b0;
            assign analog_hit = 1'b0;
        end
    endgenerate

    // Clock tick: run changes, counter selection, and increment and wrap against each port's divisor.
    always_comb
    begin
        at_zero         = request.at_position_zero;
        change          = (wanted_run_reg != running_reg);
        do_start        = (change && wanted_run_reg) || (!change && running_reg && at_zero);
        do_stop         = change && !wanted_run_reg;
        pulse_start     = do_start && at_zero && analog_en;
        reset_left_tick = pulse_start ? PULSE_LOAD : reset_left_reg;
        for (int i = 0; i < PORTS; i++) begin
            run0[i]     = at_zero ? 8'd0 : run_cnt_reg[i];
            stop1[i]    = (do_stop && en[i]) ? run0[i] : (at_zero ? 8'd0 : stop_cnt_reg[i]);
            sel_cnt[i]  = wanted_run_reg ? run0[i] : stop1[i];
            hit[i]      = en[i] && (sel_cnt[i] == 8'd0);
            inc_cnt[i]  = {1'b0, sel_cnt[i]} + 9'd1;
            over[i]     = en[i] && (inc_cnt[i] > {1'b0, port_div[i]});
            fast_cnt[i] = (inc_cnt[i] < {1'b0, port_div[i]}) ? inc_cnt[i][7:0] : 8'd0;
        end
        slow = |over;
    end

    // Divider lanes: one remainder bit per cycle.
    always_comb
    begin
        for (int i = 0; i < PORTS; i++) begin
            if ({rem_reg[i], dividend_reg[i][bit_reg]} >= {1'b0, port_div[i]})
            begin
                rem_step[i] = 8'({rem_reg[i], dividend_reg[i][bit_reg]} - {1'b0, port_div[i]});
            end
            else
            begin
                rem_step[i] = 8'({rem_reg[i], dividend_reg[i][bit_reg]});
            end
        end
    end

    assign clock_req = accept && (request.req_type == REQ_CLOCK);

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            FRONT_READY:
            begin
                if (clock_req && slow)
                begin
                    state_next = FRONT_DIVIDE;
                end
            end
            FRONT_DIVIDE:
            begin
                if (bit_reg == 4'd0)
                begin
                    state_next = FRONT_READY;
                end
            end
            default:
            begin
                state_next = FRONT_READY;
            end
        endcase
    end

    always_comb
    begin
        busy         = 1'b0;
        start_divide = 1'b0;
        divide_done  = 1'b0;
        unique case (state_reg)
            FRONT_READY:
            begin
                start_divide = clock_req && slow;
            end
            FRONT_DIVIDE:
            begin
                busy        = 1'b1;
                divide_done = (bit_reg == 4'd0);
            end
            default:
            begin
                busy = 1'b0;
            end
        endcase
    end

    always_comb
    begin
        wanted_run_next    = wanted_run_reg;
        running_next       = running_reg;
        clock_left_next    = clock_left_reg;
        delayed_clock_next = delayed_clock_reg;
        reset_left_next    = reset_left_reg;
        clock_level_next   = clock_level_reg;
        reset_level_next   = reset_level_reg;
        for (int i = 0; i < PORTS; i++) begin
            run_cnt_next[i]  = run_cnt_reg[i];
            stop_cnt_next[i] = stop_cnt_reg[i];
        end
        job = '{run_kind: MSG_NONE, run_mask: '0, tick_mask: '0,
                analog_clock: 1'b0, analog_reset: 1'b0};

        if (divide_done)
        begin
            for (int i = 0; i < PORTS; i++) begin
                if (en[i] && running_reg)
                begin
                    run_cnt_next[i] = rem_step[i];
                end
                else if (en[i])
                begin
                    stop_cnt_next[i] = rem_step[i];
                end
            end
        end

        if (accept)
        begin
            case (request.req_type)
                REQ_CLOCK:
                begin
                    running_next = wanted_run_reg;
                    for (int i = 0; i < PORTS; i++) begin
                        run_cnt_next[i]  = run0[i];
                        stop_cnt_next[i] = stop1[i];
                        if (en[i] && !slow && wanted_run_reg)
                        begin
                            run_cnt_next[i] = fast_cnt[i];
                        end
                        else if (en[i] && !slow)
                        begin
                            stop_cnt_next[i] = fast_cnt[i];
                        end
                    end
                    if (pulse_start)
                    begin
                        reset_level_next = 1'b1;
                    end
                    reset_left_next = reset_left_tick;
                    if (analog_hit)
                    begin
                        if (reset_left_tick != 8'd0)
                        begin
                            delayed_clock_next = 1'b1;
                        end
                        else if (wanted_run_reg)
                        begin
                            clock_level_next = 1'b1;
                            clock_left_next  = PULSE_LOAD;
                        end
                    end
                    if (do_start)
                    begin
                        job.run_kind = at_zero ? MSG_START : MSG_CONTINUE;
                        job.run_mask = MAX_PORTS'(msg_en);
                    end
                    else if (do_stop)
                    begin
                        job.run_kind = MSG_STOP;
                        job.run_mask = MAX_PORTS'(msg_en);
                    end
                    job.tick_mask = MAX_PORTS'(hit & msg_en);
                end
                REQ_TIMER:
                begin
                    if (delayed_clock_reg && (reset_left_reg == 8'd0))
                    begin
                        delayed_clock_next = 1'b0;
                        if (running_reg)
                        begin
                            clock_level_next = 1'b1;
                            clock_left_next  = PULSE_LOAD;
                        end
                    end
                    if (clock_left_next != 8'd0)
                    begin
                        clock_left_next = clock_left_next - 8'd1;
                        if (clock_left_next == 8'd0)
                        begin
                            clock_level_next = 1'b0;
                        end
                    end
                    if (reset_left_reg != 8'd0)
                    begin
                        reset_left_next = reset_left_reg - 8'd1;
                        if (reset_left_next == 8'd0)
                        begin
                            reset_level_next = 1'b0;
                        end
                    end
                end
                REQ_RUN:
                begin
                    wanted_run_next = request.run_request;
                end
                default:
                begin
                    wanted_run_next = wanted_run_reg;
                end
            endcase
        end
        job.analog_clock = clock_level_next;
        job.analog_reset = reset_level_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg         <= FRONT_READY;
            wanted_run_reg    <= 1'b0;
            running_reg       <= 1'b0;
            clock_left_reg    <= 8'd0;
            delayed_clock_reg <= 1'b0;
            reset_left_reg    <= 8'd0;
            clock_level_reg   <= 1'b0;
            reset_level_reg   <= 1'b0;
            bit_reg           <= 4'd0;
            for (int i = 0; i < PORTS; i++) begin
                run_cnt_reg[i]  <= 8'd0;
                stop_cnt_reg[i] <= 8'd0;
            end
            for (int r = 0; r < NUM_REGS; r++) begin
                div_reg[r] <= 8'd0;
            end
        end
        else
        begin
            state_reg         <= state_next;
            wanted_run_reg    <= wanted_run_next;
            running_reg       <= running_next;
            clock_left_reg    <= clock_left_next;
            delayed_clock_reg <= delayed_clock_next;
            reset_left_reg    <= reset_left_next;
            clock_level_reg   <= clock_level_next;
            reset_level_reg   <= reset_level_next;
            for (int i = 0; i < PORTS; i++) begin
                run_cnt_reg[i]  <= run_cnt_next[i];
                stop_cnt_reg[i] <= stop_cnt_next[i];
            end
            if (start_divide)
            begin
                bit_reg <= 4'd8;
            end
            else if (busy)
            begin
                bit_reg <= bit_reg - 4'd1;
            end
            if (cfg_write)
            begin
                for (int r = 0; r < NUM_REGS; r++) begin
                    if (cfg_index == CFG_INDEX_W'(r))
                    begin
                        div_reg[r] <= cfg_data;
                    end
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        for (int i = 0; i < PORTS; i++) begin
            if (start_divide)
            begin
                dividend_reg[i] <= inc_cnt[i];
                rem_reg[i]      <= 8'd0;
            end
            else if (busy)
            begin
                rem_reg[i] <= rem_step[i];
            end
        end
    end

endmodule

>>> sv/scod_back.sv
// Back part: turns message jobs into results via an output register, one per cycle unless stalled.
module scod_back
    import scod_pkg::*;
(
    input  logic clk,
    input  logic rst_n,
    input  job_t job,
    input  logic job_valid,
    output logic job_pop,
    output res_t result,
    output logic res_valid,
    input  logic res_taken
);

    logic                 out_valid_reg, out_valid_next;
    res_t                 out_reg, out_next;
    logic                 started_reg, started_next;
    logic [MAX_PORTS-1:0] run_left_reg, run_left_next;
    logic [MAX_PORTS-1:0] tick_left_reg, tick_left_next;
    logic [2:0]           count_reg, count_next;
    logic [MAX_PORTS-1:0] run_cur;
    logic [MAX_PORTS-1:0] tick_cur;
    logic [2:0]           count_cur;
    logic                 advance;
    logic                 is_last;

    assign result    = out_reg;
    assign res_valid = out_valid_reg;
    assign advance   = job_valid && (!out_valid_reg || res_taken);

    always_comb
    begin
        run_cur        = started_reg ? run_left_reg : job.run_mask;
        tick_cur       = started_reg ? tick_left_reg : job.tick_mask;
        count_cur      = started_reg ? count_reg : 3'd0;
        run_left_next  = run_cur;
        tick_left_next = tick_cur;
        out_next       = out_reg;
        out_valid_next = out_valid_reg && !res_taken;
        started_next   = started_reg;
        count_next     = count_reg;
        job_pop        = 1'b0;
        is_last        = 1'b1;

        if (advance)
        begin
            out_next.analog_clock = job.analog_clock;
            out_next.analog_reset = job.analog_reset;
            if (run_cur != '0)
            begin
                out_next.msg_kind = job.run_kind;
                out_next.port     = lowest_index(run_cur);
                run_left_next     = run_cur & (run_cur - MAX_PORTS'(1));
            end
            else if (tick_cur != '0)
            begin
                out_next.msg_kind = MSG_TICK;
                out_next.port     = lowest_index(tick_cur);
                tick_left_next    = tick_cur & (tick_cur - MAX_PORTS'(1));
            end
            else
            begin
                out_next.msg_kind = MSG_NONE;
                out_next.port     = '0;
            end
            is_last = ((run_left_next == '0) && (tick_left_next == '0))
                      || (count_cur == 3'(MAX_RESULTS - 1));
            out_next.last  = is_last;
            out_valid_next = 1'b1;
            job_pop        = is_last;
            started_next   = !is_last;
            count_next     = count_cur + 3'd1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
            started_reg   <= 1'b0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
            started_reg   <= started_next;
        end
    end

    always_ff @(posedge clk)
    begin
        out_reg       <= out_next;
        run_left_reg  <= run_left_next;
        tick_left_reg <= tick_left_next;
        count_reg     <= count_next;
    end

endmodule

>>> sv/sequencer_clock_output_divider.sv
// Top level of the sequencer clock output divider.
// Requests enter through a queue-like port and each one yields one or more results, one
// result per clock cycle at most: a request that causes n messages gives n results (at most
// 8, at least 1); the back stage emits one message a cycle while no result waits unpopped.
// A short job queue lets requests be taken while earlier results are still being sent.
// A clock tick that finds an enabled port's counter at or above its divisor, which can
// happen after a divisor is lowered, holds full high while the per-port remainder lanes work
// out the new counts one bit a cycle. The user is to write divisors through the configuration
// port only while the block is idle, which it does not check; unused indexes ignore writes.
module sequencer_clock_output_divider
    import scod_pkg::*;
#(
    parameter int PORTS       = DEFAULT_PORTS,
    parameter int ANALOG_PORT = DEFAULT_ANALOG_PORT,
    parameter int PULSE_LEN   = DEFAULT_PULSE_LEN
)
(
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   push,
    output logic                   full,
    input  req_t                   request,
    output logic                   empty,
    input  logic                   pop,
    output res_t                   result,
    input  logic                   cfg_write,
    input  logic [CFG_INDEX_W-1:0] cfg_index,
    input  logic [DATA_W-1:0]      cfg_data
);

    logic accept;
    logic front_busy;
    job_t front_job;
    logic q_full;
    logic q_empty;
    job_t q_job;
    logic q_pop;
    logic res_valid;

    assign full   = front_busy || q_full;
    assign accept = push && !full;
    assign empty  = !res_valid;

    scod_front #(
        .PORTS       (PORTS),
        .ANALOG_PORT (ANALOG_PORT),
        .PULSE_LEN   (PULSE_LEN)
    ) u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_write (cfg_write),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .accept    (accept),
        .request   (request),
        .busy      (front_busy),
        .job       (front_job)
    );

    scod_job_queue u_queue (
        .clk     (clk),
        .rst_n   (rst_n),
        .push    (accept),
        .job_in  (front_job),
        .full    (q_full),
        .pop     (q_pop),
        .job_out (q_job),
        .empty   (q_empty)
    );

    scod_back u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .job       (q_job),
        .job_valid (!q_empty),
        .job_pop   (q_pop),
        .result    (result),
        .res_valid (res_valid),
        .res_taken (pop)
    );

    a_none_is_last: assert property (@(posedge clk) disable iff (!rst_n)
        (!empty && result.msg_kind == MSG_NONE) |-> result.last)
        else $error("A result without a message is not the last one of its request.");

    a_port_valid: assert property (@(posedge clk) disable iff (!rst_n)
        (!empty && result.msg_kind != MSG_NONE)
            |-> ((int'(result.port) < PORTS) && (int'(result.port) != ANALOG_PORT)))
        else $error("A message names a port that is absent or the analog port.");

    a_no_pop_empty_queue: assert property (@(posedge clk) disable iff (!rst_n)
        q_pop |-> !q_empty)
        else $error("The back stage finished a job that was not in the queue.");

endmodule

>>> sim/tb.sv
// Self-checking testbench for the sequencer clock output divider.
`timescale 1ns / 100ps

module tb;
    import scod_pkg::*;

    localparam logic [1:0]             REQ_UNKNOWN  = 2'd3;
    localparam logic [CFG_INDEX_W-1:0] UNUSED_INDEX = 3'd7;
    localparam int                     PULSE_LOAD   = DEFAULT_PULSE_LEN + 1;
    localparam int                     QUIET_CYCLES = 24;
    localparam int                     RANDOM_ITEMS = 138;
    localparam int                     PHASES       = 6;

    class message_scoreboard;
        logic [7:0]        divisor [NUM_REGS];
        logic [7:0]        run_counts [DEFAULT_PORTS];
        logic [7:0]        stop_counts [DEFAULT_PORTS];
        bit                wanted_run;
        bit                running;
        bit                delayed_clock;
        bit                clock_level;
        bit                reset_level;
        int                clock_pulse_left;
        int                reset_pulse_left;
        msg_kind_t         step_kinds [$];
        logic [PORT_W-1:0] step_ports [$];
        res_t              awaited [$];
        int                errors;

        function new();
            foreach (divisor[i])
            begin
                divisor[i] = '0;
            end
            foreach (run_counts[i])
            begin
                run_counts[i] = '0;
                stop_counts[i] = '0;
            end
            wanted_run = 0;
            running = 0;
            delayed_clock = 0;
            clock_level = 0;
            reset_level = 0;
            clock_pulse_left = 0;
            reset_pulse_left = 0;
            errors = 0;
        endfunction

        function void set_divisor(int idx, logic [7:0] value);
            if (idx < NUM_REGS)
            begin
                divisor[idx] = value;
            end
        endfunction

        function logic [7:0] divisor_of(int p);
            return (p < NUM_REGS) ? divisor[p] : 8'd0;
        endfunction

        function int outstanding();
            return awaited.size();
        endfunction

        function void add_message(msg_kind_t kind, int p);
            if (step_kinds.size() < MAX_RESULTS)
            begin
                step_kinds.push_back(kind);
                step_ports.push_back(PORT_W'(p));
            end
        endfunction

        function void start_ports(bit at_zero);
            for (int p = 0; p < DEFAULT_PORTS; p++)
            begin
                if (divisor_of(p) != 0)
                begin
                    if (p == DEFAULT_ANALOG_PORT)
                    begin
                        if (at_zero)
                        begin
                            reset_level = 1;
                            reset_pulse_left = PULSE_LOAD;
                        end
                    end
                    else
                    begin
                        add_message(at_zero ? MSG_START : MSG_CONTINUE, p);
                    end
                end
            end
        endfunction

        function void note_request(req_t r);
            logic [7:0] d;
            logic [7:0] cnt;
            res_t       item;
            int         n;
            step_kinds.delete();
            step_ports.delete();
            case (r.req_type)
                REQ_CLOCK:
                begin
                    if (r.at_position_zero)
                    begin
                        foreach (run_counts[i])
                        begin
                            run_counts[i] = '0;
                            stop_counts[i] = '0;
                        end
                    end
                    if (wanted_run != running)
                    begin
                        running = wanted_run;
                        if (running)
                        begin
                            start_ports(r.at_position_zero);
                        end
                        else
                        begin
                            for (int p = 0; p < DEFAULT_PORTS; p++)
                            begin
                                if (divisor_of(p) != 0)
                                begin
                                    stop_counts[p] = run_counts[p];
                                    if (p != DEFAULT_ANALOG_PORT)
                                    begin
                                        add_message(MSG_STOP, p);
                                    end
                                end
                            end
                        end
                    end
                    else if (running && r.at_position_zero)
                    begin
                        start_ports(1'b1);
                    end
                    for (int p = 0; p < DEFAULT_PORTS; p++)
                    begin
                        d = divisor_of(p);
                        if (d != 0)
                        begin
                            cnt = running ? run_counts[p] : stop_counts[p];
                            if (cnt == 0)
                            begin
                                if (p == DEFAULT_ANALOG_PORT)
                                begin
                                    if (reset_pulse_left != 0)
                                    begin
                                        delayed_clock = 1;
                                    end
                                    else if (running)
                                    begin
                                        clock_level = 1;
                                        clock_pulse_left = PULSE_LOAD;
                                    end
                                end
                                else
                                begin
                                    add_message(MSG_TICK, p);
                                end
                            end
                            cnt = 8'((int'(cnt) + 1) % int'(d));
                            if (running)
                            begin
                                run_counts[p] = cnt;
                            end
                            else
                            begin
                                stop_counts[p] = cnt;
                            end
                        end
                    end
                end
                REQ_TIMER:
                begin
                    if (delayed_clock && reset_pulse_left == 0)
                    begin
                        delayed_clock = 0;
                        if (running)
                        begin
                            clock_level = 1;
                            clock_pulse_left = PULSE_LOAD;
                        end
                    end
                    if (clock_pulse_left != 0)
                    begin
                        clock_pulse_left--;
                        if (clock_pulse_left == 0)
                        begin
                            clock_level = 0;
                        end
                    end
                    if (reset_pulse_left != 0)
                    begin
                        reset_pulse_left--;
                        if (reset_pulse_left == 0)
                        begin
                            reset_level = 0;
                        end
                    end
                end
                REQ_RUN:
                begin
                    wanted_run = r.run_request;
                end
                default:
                begin
                end
            endcase
            n = step_kinds.size();
            if (n == 0)
            begin
                step_kinds.push_back(MSG_NONE);
                step_ports.push_back('0);
                n = 1;
            end
            for (int k = 0; k < n; k++)
            begin
                item.msg_kind = step_kinds[k];
                item.port = step_ports[k];
                item.analog_clock = clock_level;
                item.analog_reset = reset_level;
                item.last = (k == n - 1);
                awaited.push_back(item);
            end
        endfunction

        task report(string what);
            $display("mismatch at %0t ns: %s", $time, what);
            errors++;
        endtask

        task check_result(res_t got);
            res_t want;
            if (awaited.size() == 0)
            begin
                report($sformatf("unexpected result %p", got));
                return;
            end
            want = awaited.pop_front();
            if (got.msg_kind !== want.msg_kind)
                report($sformatf("msg_kind got %0d want %0d", got.msg_kind, want.msg_kind));
            if (got.port !== want.port)
                report($sformatf("port got %0d want %0d", got.port, want.port));
            if (got.analog_clock !== want.analog_clock)
                report($sformatf("analog_clock got %b want %b", got.analog_clock,
                                 want.analog_clock));
            if (got.analog_reset !== want.analog_reset)
                report($sformatf("analog_reset got %b want %b", got.analog_reset,
                                 want.analog_reset));
            if (got.last !== want.last)
                report($sformatf("last got %b want %b", got.last, want.last));
        endtask
    endclass

    logic                   clk;
    logic                   rst_n;
    logic                   push;
    logic                   full;
    req_t                   request;
    logic                   empty;
    logic                   pop;
    res_t                   result;
    logic                   cfg_write;
    logic [CFG_INDEX_W-1:0] cfg_index;
    logic [DATA_W-1:0]      cfg_data;

    message_scoreboard board;
    logic [7:0]        planned [NUM_REGS];
    bit                tx_calm;
    bit                rx_calm;

    sequencer_clock_output_divider DUT (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .full      (full),
        .request   (request),
        .empty     (empty),
        .pop       (pop),
        .result    (result),
        .cfg_write (cfg_write),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    initial
    begin
        clk = 1'b0;
    end

    always #5 clk = ~clk;

    function automatic req_t compose(logic [1:0] kind, bit at_zero, bit run);
        req_t r;
        r.req_type = req_type_t'(kind);
        r.at_position_zero = at_zero;
        r.run_request = run;
        return r;
    endfunction

    function automatic req_t random_request();
        int pick;
        pick = $urandom_range(0, 99);
        if (pick < 45)
            return compose(REQ_CLOCK, $urandom_range(0, 99) < 15, 1'($urandom_range(0, 1)));
        if (pick < 80)
            return compose(REQ_TIMER, 1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)));
        if (pick < 95)
            return compose(REQ_RUN, 1'($urandom_range(0, 1)), $urandom_range(0, 99) < 70);
        return compose(REQ_UNKNOWN, 1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)));
    endfunction

    task automatic send_request(input req_t r);
        int gap;
        bit taken;
        gap = tx_calm ? 0 : $urandom_range(0, 10);
        if (gap > 0)
        begin
            push <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        push <= 1'b1;
        request <= r;
        do
        begin
            @(negedge clk);
            taken = !full;
            @(posedge clk);
        end
        while (!taken);
        board.note_request(r);
    endtask

    task automatic settle();
        push <= 1'b0;
        while (board.outstanding() != 0)
        begin
            @(posedge clk);
        end
        repeat (QUIET_CYCLES) @(posedge clk);
    endtask

    task automatic program_divisors();
        for (int i = 0; i < NUM_REGS; i++)
        begin
            cfg_write <= 1'b1;
            cfg_index <= CFG_INDEX_W'(i);
            cfg_data <= planned[i];
            @(posedge clk);
            board.set_divisor(i, planned[i]);
        end
        cfg_write <= 1'b1;
        cfg_index <= UNUSED_INDEX;
        cfg_data <= DATA_W'($urandom);
        @(posedge clk);
        cfg_write <= 1'b0;
    endtask

    initial
    begin
        res_t snap;
        int   stall;
        bit   got;
        pop = 1'b0;
        wait (rst_n === 1'b1);
        @(posedge clk);
        forever
        begin
            stall = rx_calm ? 0 : $urandom_range(0, 10);
            if (stall > 0)
            begin
                pop <= 1'b0;
                repeat (stall) @(posedge clk);
            end
            pop <= 1'b1;
            do
            begin
                @(negedge clk);
                got = !empty;
                snap = result;
                @(posedge clk);
            end
            while (!got);
            board.check_result(snap);
        end
    end

    initial
    begin
        int counted;
        board = new();
        rst_n = 1'b0;
        push = 1'b0;
        request = '0;
        cfg_write = 1'b0;
        cfg_index = '0;
        cfg_data = '0;
        tx_calm = 1'b0;
        rx_calm = 1'b0;
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Every port disabled: only empty results, whatever the request.
        send_request(compose(REQ_CLOCK, 1'b1, 1'b0));
        send_request(compose(REQ_TIMER, 1'b0, 1'b1));
        send_request(compose(REQ_UNKNOWN, 1'b1, 1'b1));
        send_request(compose(REQ_RUN, 1'b0, 1'b1));
        send_request(compose(REQ_CLOCK, 1'b0, 1'b0));
        settle();

        // All ports at divisor one: a start fills a full set of results.
        foreach (planned[i])
        begin
            planned[i] = 8'd1;
        end
        program_divisors();
        send_request(compose(REQ_RUN, 1'b0, 1'b0));
        send_request(compose(REQ_CLOCK, 1'b1, 1'b0));
        send_request(compose(REQ_RUN, 1'b0, 1'b1));
        send_request(compose(REQ_CLOCK, 1'b1, 1'b0));
        send_request(compose(REQ_CLOCK, 1'b0, 1'b0));
        // The analog clock waits for the reset pulse to end.
        repeat (13) send_request(compose(REQ_TIMER, 1'b0, 1'b0));
        send_request(compose(REQ_RUN, 1'b0, 1'b0));
        send_request(compose(REQ_RUN, 1'b0, 1'b1));
        send_request(compose(REQ_CLOCK, 1'b0, 1'b0));
        settle();

        for (int phase = 0; phase < PHASES; phase++)
        begin
            foreach (planned[i])
            begin
                case (phase)
                    0: planned[i] = 8'd255;
                    1: planned[i] = 8'($urandom_range(1, 4));
                    2: planned[i] = 8'd1;
                    3: planned[i] = 8'($urandom_range(0, 255));
                    4: planned[i] = 8'($urandom_range(0, 3));
                    default: planned[i] = 8'($urandom_range(0, 12));
                endcase
            end
            program_divisors();
            tx_calm = ($urandom_range(0, 3) == 0);
            rx_calm = ($urandom_range(0, 3) == 0);
            counted = 0;
            while (counted < RANDOM_ITEMS / PHASES)
            begin
                request_loop:
                begin
                    req_t r;
                    r = random_request();
                    send_request(r);
                    if (r.req_type != req_type_t'(REQ_UNKNOWN))
                        counted++;
                end
            end
            settle();
        end

        if (board.errors == 0 && board.outstanding() == 0)
            $display("tb: success");
        else
            $display("tb: failure");
        $finish;
    end

    initial
    begin
        #5000000;
        $display("tb: failure");
        $finish;
    end

endmodule
